[rtl/core/ksq_pkg.sv]
// shared types, status codes and the scan code table for the keyboard queue
`timescale 1ns / 1ps

package ksq_pkg;

  localparam logic [7:0] BREAK_PREFIX = 8'hF0;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CHAR    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_BAD_BRK = 3'd3;
  localparam logic [2:0] ST_DROPPED = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // decode and update the queue
  } ctrl_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ch;
  } lookup_t;

  // scan code set 2 make codes for digits, backspace, enter and letters
  function automatic lookup_t scan_lookup(input logic [7:0] code);
    lookup_t r;
    r.hit = 1'b1;
    r.ch  = 7'd0;
    unique case (code)
      8'h16: r.ch = 7'h31;
      8'h1E: r.ch = 7'h32;
      8'h26: r.ch = 7'h33;
      8'h25: r.ch = 7'h34;
      8'h2E: r.ch = 7'h35;
      8'h36: r.ch = 7'h36;
      8'h3D: r.ch = 7'h37;
      8'h3E: r.ch = 7'h38;
      8'h46: r.ch = 7'h39;
      8'h45: r.ch = 7'h30;
      8'h66: r.ch = 7'h08;
      8'h5A: r.ch = 7'h0A;
      8'h1C: r.ch = 7'h41;
      8'h32: r.ch = 7'h42;
      8'h21: r.ch = 7'h43;
      8'h23: r.ch = 7'h44;
      8'h24: r.ch = 7'h45;
      8'h2B: r.ch = 7'h46;
      8'h34: r.ch = 7'h47;
      8'h33: r.ch = 7'h48;
      8'h43: r.ch = 7'h49;
      8'h3B: r.ch = 7'h4A;
      8'h42: r.ch = 7'h4B;
      8'h4B: r.ch = 7'h4C;
      8'h3A: r.ch = 7'h4D;
      8'h31: r.ch = 7'h4E;
      8'h44: r.ch = 7'h4F;
      8'h4D: r.ch = 7'h50;
      8'h15: r.ch = 7'h51;
      8'h2D: r.ch = 7'h52;
      8'h1B: r.ch = 7'h53;
      8'h2C: r.ch = 7'h54;
      8'h3C: r.ch = 7'h55;
      8'h2A: r.ch = 7'h56;
      8'h1D: r.ch = 7'h57;
      8'h22: r.ch = 7'h58;
      8'h35: r.ch = 7'h59;
      8'h1A: r.ch = 7'h5A;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ksq_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ksq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/core/ksq_ctrl.sv]
// controller state machine: accept, execute, respond
`timescale 1ns / 1ps

module ksq_ctrl
  import ksq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_EXEC;
      S_EXEC: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o     = 1'b1;
    done_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_RESP: done_o = 1'b1;
      default: busy_o = 1'b0;
    endcase
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> cmd_o.exec)
    else $error("accepted item not executed next cycle");

  a_exec_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> done_o)
    else $error("execute not followed by result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe longer than one cycle");

endmodule

[rtl/core/ksq_dpath.sv]
// datapath: item registers, scan decode, break flag and character fifo
`timescale 1ns / 1ps

module ksq_dpath
  import ksq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  logic       func_i,
  input  logic [7:0] scan_byte_i,
  output logic [6:0] char_out_o,
  output logic [2:0] status_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(2 * QUEUE_DEPTH);

  logic          func_q;
  logic [7:0]    byte_q;
  logic          brk_q, brk_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    status_q, status_d;
  logic          popped_q, popped_d;

  lookup_t       lk;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic          full, empty;
  logic          we, re;
  logic [6:0]    rdata;

  assign lk       = scan_lookup(byte_q);
  assign full     = (count_q == CW'(QUEUE_DEPTH));
  assign empty    = (count_q == '0);
  assign tail_sum = SW'(head_q) + SW'(count_q);
  // head + count stays below twice the depth, one subtract wraps it
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      byte_q <= scan_byte_i;
    end
  end

  always_comb begin
    brk_d    = brk_q;
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    popped_d = popped_q;
    we       = 1'b0;
    re       = 1'b0;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      popped_d = 1'b0;
      priority if (func_q) begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re       = 1'b1;
          popped_d = 1'b1;
          status_d = ST_CHAR;
          head_d   = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
          count_d  = count_q - CW'(1);
        end
      end else if (brk_q) begin
        // known code ends the break, unknown one leaves it armed
        if (lk.hit) begin
          brk_d = 1'b0;
        end else begin
          status_d = ST_BAD_BRK;
        end
      end else if (byte_q == BREAK_PREFIX) begin
        brk_d = 1'b1;
      end else if (full) begin
        status_d = ST_DROPPED;
      end else begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q    <= 1'b0;
      head_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      popped_q <= 1'b0;
    end else begin
      brk_q    <= brk_d;
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  ksq_ram #(
    .WIDTH (7),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail),
    .wdata_i (lk.ch),
    .re_i    (re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign char_out_o = popped_q ? rdata : 7'd0;
  assign status_o   = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the queue");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    popped_q |-> (status_q == ST_CHAR))
    else $error("popped item without char status");

endmodule

[rtl/core/keyboard_scancode_to_char_queue_unit.sv]
// top level: keyboard scan code decoder with character queue
// usage:
//   drive func_i and scan_byte_i and raise start_i; the item is taken at a
//   rising edge with start_i high and busy_o low. func_i low feeds one scan
//   set 2 byte: known make codes queue their ascii character, unknown ones
//   queue 0, an f0 byte arms a break and the following code is swallowed.
//   func_i high pops the oldest character.
//   each item gives exactly one result on char_out_o and status_o, shown for
//   one cycle with done_o high; the receiver cannot stall it.
// timing:
//   done_o rises after the execute state (whose closing edge also registers
//   the queue read) and the result is taken at the closing edge of the
//   result state. busy_o falls with the end of the result cycle, so a new
//   item is taken only after the last one has passed through the controller
//   states execute and result.
// reset:
//   rst_ni clears the break flag and empties the queue; queue storage itself
//   is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module keyboard_scancode_to_char_queue_unit
  import ksq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       func_i,
  input  logic [7:0] scan_byte_i,
  output logic       done_o,
  output logic [6:0] char_out_o,
  output logic [2:0] status_o
);

  ctrl_cmd_t cmd;

  ksq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  ksq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .scan_byte_i (scan_byte_i),
    .char_out_o  (char_out_o),
    .status_o    (status_o)
  );

endmodule

[verif/tb_keyboard_scancode_to_char_queue_unit.sv]
// self-checking testbench for the keyboard scan code decoder and character queue
`timescale 1ns / 1ps

import ksq_pkg::*;

class char_queue_tracker;
  logic [7:0]  make_tab [38];
  logic [6:0]  char_tab [38];
  bit          brk_armed;
  logic [6:0]  chars_held [8];
  int unsigned head;
  int unsigned count;
  logic [6:0]  due_char [$];
  logic [2:0]  due_status [$];
  int          errors;

  function new();
    make_tab = '{8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45,
                 8'h66, 8'h5A,
                 8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34,
                 8'h33, 8'h43, 8'h3B, 8'h42, 8'h4B, 8'h3A, 8'h31,
                 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C,
                 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A};
    // digits 1-9 and 0, backspace, line feed, then A to Z
    for (int i = 0; i < 10; i++) char_tab[i] = 7'h31 + 7'(i);
    char_tab[9]  = 7'h30;
    char_tab[10] = 7'h08;
    char_tab[11] = 7'h0A;
    for (int i = 0; i < 26; i++) char_tab[12 + i] = 7'h41 + 7'(i);
    brk_armed = 1'b0;
    head      = 0;
    count     = 0;
    errors    = 0;
  endfunction

  function void decode(input logic [7:0] code, output bit hit, output logic [6:0] ch);
    hit = 1'b0;
    ch  = 7'd0;
    for (int i = 0; i < 38; i++) begin
      if (make_tab[i] == code) begin
        hit = 1'b1;
        ch  = char_tab[i];
      end
    end
  endfunction

  function void note_item(input bit rd, input logic [7:0] code);
    bit         hit;
    logic [6:0] ch;
    logic [6:0] out_ch;
    logic [2:0] st;
    out_ch = 7'd0;
    st     = ST_OK;
    if (rd) begin
      if (count == 0) begin
        st = ST_EMPTY;
      end else begin
        out_ch = chars_held[head];
        head   = (head + 1) % 8;
        count--;
        st     = ST_CHAR;
      end
    end else if (brk_armed) begin
      decode(code, hit, ch);
      // an unknown code after the prefix keeps the break armed
      if (hit) brk_armed = 1'b0;
      else st = ST_BAD_BRK;
    end else if (code == BREAK_PREFIX) begin
      brk_armed = 1'b1;
    end else begin
      decode(code, hit, ch);
      if (count >= 8) begin
        st = ST_DROPPED;
      end else begin
        chars_held[(head + count) % 8] = ch;
        count++;
      end
    end
    due_char.push_back(out_ch);
    due_status.push_back(st);
  endfunction

  function void check_result(input logic [6:0] ch, input logic [2:0] st);
    logic [6:0] want_ch;
    logic [2:0] want_st;
    if (due_char.size() == 0) begin
      $display("%0t: result with no item outstanding, char_out %h status %0d", $time, ch, st);
      errors++;
      return;
    end
    want_ch = due_char.pop_front();
    want_st = due_status.pop_front();
    if (ch !== want_ch) begin
      $display("%0t: char_out expected %h got %h", $time, want_ch, ch);
      errors++;
    end
    if (st !== want_st) begin
      $display("%0t: status expected %0d got %0d", $time, want_st, st);
      errors++;
    end
  endfunction

  function int pending();
    return due_char.size();
  endfunction
endclass

module tb_keyboard_scancode_to_char_queue_unit;

  localparam int NUM_ITEMS  = 1650;
  localparam int IDLE_LIMIT = 500;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic       func_i      = 1'b0;
  logic [7:0] scan_byte_i = 8'h00;
  logic       busy_o;
  logic       done_o;
  logic [6:0] char_out_o;
  logic [2:0] status_o;

  char_queue_tracker tracker = new();
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  keyboard_scancode_to_char_queue_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .scan_byte_i (scan_byte_i),
    .done_o      (done_o),
    .char_out_o  (char_out_o),
    .status_o    (status_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // results first, then the item taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(char_out_o, status_o);
      if (start_i && !busy_o) tracker.note_item(func_i, scan_byte_i);
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input bit rd, input logic [7:0] code);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i     <= 1'b1;
    func_i      <= rd;
    scan_byte_i <= code;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_scan(input logic [7:0] code);
    send_item(1'b0, code);
  endtask

  task automatic send_read();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic directed_items();
    send_item(1'b1, 8'hFF);  // read while empty
    send_scan(8'h16);
    send_scan(8'h1A);
    send_scan(8'h66);        // backspace
    send_scan(8'h5A);        // enter
    send_scan(8'h00);        // unknown, queues a zero
    send_scan(8'hFF);
    send_scan(BREAK_PREFIX);
    send_scan(BREAK_PREFIX); // prefix again while armed
    send_scan(8'h00);        // unknown break code
    send_scan(8'h1C);        // swallowed, clears the break
    repeat (6) send_item(1'b1, 8'h00);
    // fill the queue, then one more is dropped
    for (int i = 0; i < 9; i++) send_scan(tracker.make_tab[12 + i]);
  endtask

  task automatic random_items();
    int mode;
    int seg_left;
    int rd_weight;
    int pick;
    seg_left = 0;
    mode     = 0;
    while (items_sent < NUM_ITEMS) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      rd_weight = (mode == 0) ? 15 : (mode == 1) ? 40 : 65;
      if ($urandom_range(0, 99) < rd_weight) begin
        send_read();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_scan(tracker.make_tab[$urandom_range(0, 37)]);
        end else if (pick < 80) begin
          // key release: prefix then a known code
          send_scan(BREAK_PREFIX);
          send_scan(tracker.make_tab[$urandom_range(0, 37)]);
        end else if (pick < 88) begin
          send_scan(BREAK_PREFIX);
          send_scan(8'($urandom_range(0, 255)));
        end else begin
          send_scan(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    random_items();
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
